>>> rtl/positional_list_insert_dump_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list insert/dump block
// Shared forms for the port-level checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DUMP_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DUMP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define PLID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define PLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Types, codes and sizes shared by the positional list insert/dump block.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;

    // result status codes
    localparam logic [1:0] ST_ELEMENT = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // input item
    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0]               status;
        logic                     direction;
        logic signed [DATA_W-1:0] element;
        logic                     pass_end;
        logic                     last;
    } out_item_t;

    // what each cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROT_FWD,
        CELL_ROT_BWD
    } cell_op_t;

    // control broadcast along the chain
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-2:0] pos;
    } cell_ctrl_t;

endpackage

>>> rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list entry. Loads on insert, or takes a neighbour's entry when the
// chain rotates during a dump.
// ----------------------------------------------------------------------------
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  plid_pkg::cell_ctrl_t              ctrl,
    input  logic signed [plid_pkg::DATA_W-1:0] ins_value,
    input  logic signed [plid_pkg::DATA_W-1:0] left_data,
    input  logic signed [plid_pkg::DATA_W-1:0] right_data,
    output logic signed [plid_pkg::DATA_W-1:0] data
);

    localparam logic [plid_pkg::POS_W-2:0] MY_IDX = (plid_pkg::POS_W-1)'(IDX);

    logic signed [plid_pkg::DATA_W-1:0] data_reg;
    logic signed [plid_pkg::DATA_W-1:0] data_next;

    // next entry value
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            plid_pkg::CELL_INSERT:
            begin
                if (MY_IDX > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == ctrl.pos)
                begin
                    data_next = ins_value;
                end
            end
            plid_pkg::CELL_ROT_FWD: data_next = right_data;
            plid_pkg::CELL_ROT_BWD: data_next = left_data;
            default:                data_next = data_reg;
        endcase
    end

    // entry storage, no reset: entries above the count are never emitted
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/positional_list_insert_dump.sv
// ----------------------------------------------------------------------------
// positional_list_insert_dump
// Ordered list held in a chain of cells; inserts a value at a position and
// dumps the list front to back and back to front.
//
//  channel | ports                      | handshake
//  --------+----------------------------+------------------------------------
//  input   | start, busy, item          | taken when start && !busy
//  result  | result_valid, result       | valid-only, no back-pressure
//
//  A valid insert loads the item, then makes two full rotations of the cell
//  chain, forward then backward, during which only the stored entries are
//  emitted. A rejected item gives its single result on the next cycle.
//  Reset empties the list at once (the count is cleared). The receiver
//  cannot stall; results are never held.
// ----------------------------------------------------------------------------
module positional_list_insert_dump #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plid_pkg::in_item_t  item,
    output logic                result_valid,
    output plid_pkg::out_item_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CYC_W = $clog2(CAPACITY);
    localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_BWD
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CYC_W-1:0]     cyc_reg;
    logic                 result_valid_reg;
    plid_pkg::out_item_t  result_reg;

    logic                 accept;
    logic                 pos_bad;
    logic                 list_full;
    logic                 do_insert;
    logic                 fwd_emit;
    logic                 fwd_end;
    logic [CNT_W:0]       bwd_sum;
    logic                 bwd_emit;
    plid_pkg::cell_ctrl_t ctrl;

    logic signed [plid_pkg::DATA_W-1:0] cell_q [CAPACITY];

    // input checks
    assign accept    = start && (state_reg == S_IDLE);
    assign pos_bad   = item.position[plid_pkg::POS_W-1] ||
                       (item.position[plid_pkg::POS_W-2:0] > (plid_pkg::POS_W-1)'(count_reg));
    assign list_full = (count_reg == CNT_W'(CAPACITY));
    assign do_insert = accept && !pos_bad && !list_full;

    // emit windows of the two rotations
    assign fwd_emit = (CNT_W'(cyc_reg) < count_reg);
    assign fwd_end  = ((CNT_W'(cyc_reg) + CNT_W'(1)) == count_reg);
    assign bwd_sum  = (CNT_W+1)'(cyc_reg) + (CNT_W+1)'(count_reg);
    assign bwd_emit = (bwd_sum >= (CNT_W+1)'(CAPACITY));

    // chain control
    always_comb
    begin
        ctrl.pos = item.position[plid_pkg::POS_W-2:0];
        if (do_insert)
        begin
            ctrl.op = plid_pkg::CELL_INSERT;
        end
        else if (state_reg == S_FWD)
        begin
            ctrl.op = plid_pkg::CELL_ROT_FWD;
        end
        else if (state_reg == S_BWD)
        begin
            ctrl.op = plid_pkg::CELL_ROT_BWD;
        end
        else
        begin
            ctrl.op = plid_pkg::CELL_HOLD;
        end
    end

    // cell chain, closed into a ring for the rotations
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        plid_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_value  (item.value),
            .left_data  (cell_q[(i + CAPACITY - 1) % CAPACITY]),
            .right_data (cell_q[(i + 1) % CAPACITY]),
            .data       (cell_q[i])
        );
    end

    // sequencer, count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            cyc_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    cyc_reg          <= '0;
                    result_valid_reg <= accept && (pos_bad || list_full);
                    if (accept)
                    begin
                        if (pos_bad || list_full)
                        begin
                            result_reg <= '{status:    pos_bad ? plid_pkg::ST_INVALID
                                                               : plid_pkg::ST_FULL,
                                            direction: 1'b0,
                                            element:   '0,
                                            pass_end:  1'b0,
                                            last:      1'b1};
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            state_reg <= S_FWD;
                        end
                    end
                end
                S_FWD:
                begin
                    // front cell is emitted, chain rotates toward the front
                    result_valid_reg     <= fwd_emit;
                    result_reg.status    <= plid_pkg::ST_ELEMENT;
                    result_reg.direction <= 1'b0;
                    result_reg.element   <= cell_q[0];
                    result_reg.pass_end  <= fwd_end;
                    result_reg.last      <= 1'b0;
                    if (cyc_reg == CYC_LAST)
                    begin
                        cyc_reg   <= '0;
                        state_reg <= S_BWD;
                    end
                    else
                    begin
                        cyc_reg <= cyc_reg + CYC_W'(1);
                    end
                end
                S_BWD:
                begin
                    // back cell is emitted, chain rotates toward the back
                    result_valid_reg     <= bwd_emit;
                    result_reg.status    <= plid_pkg::ST_ELEMENT;
                    result_reg.direction <= 1'b1;
                    result_reg.element   <= cell_q[CAPACITY-1];
                    result_reg.pass_end  <= (cyc_reg == CYC_LAST);
                    result_reg.last      <= (cyc_reg == CYC_LAST);
                    if (cyc_reg == CYC_LAST)
                    begin
                        cyc_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cyc_reg <= cyc_reg + CYC_W'(1);
                    end
                end
                default:
                begin
                    result_valid_reg <= 1'b0;
                    state_reg        <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/plid_checker.sv
// ----------------------------------------------------------------------------
// plid_checker
// Port-level checks for the positional list insert/dump block.
// ----------------------------------------------------------------------------
`include "positional_list_insert_dump_assert.svh"

module plid_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input plid_pkg::in_item_t  item,
    input logic                result_valid,
    input plid_pkg::out_item_t result
);

    // negative position is rejected on the very next cycle
    `PLID_ASSERT_NEXT(a_neg_pos, clk, rst_n, start && !busy && item.position[plid_pkg::POS_W-1], result_valid && (result.status == plid_pkg::ST_INVALID) && result.last)

    // an accepted item either starts a dump or is answered at once
    `PLID_ASSERT_NEXT(a_accept_reacts, clk, rst_n, start && !busy, busy || result_valid)

    // error results stand alone
    `PLID_ASSERT_NOW(a_err_last, clk, rst_n, result_valid && (result.status != plid_pkg::ST_ELEMENT), result.last && !result.pass_end && (result.element == '0))

    // the final element of an insert closes the backward pass
    `PLID_ASSERT_NOW(a_last_bwd, clk, rst_n, result_valid && result.last && (result.status == plid_pkg::ST_ELEMENT), result.direction && result.pass_end)

endmodule

bind positional_list_insert_dump plid_checker u_plid_checker (.*);
